@@ sv/llfp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and codes for the leader/length frame parser
package llfp_pkg;

  // result status codes
  localparam logic [1:0] StHunt    = 2'd0;
  localparam logic [1:0] StStored  = 2'd1;
  localparam logic [1:0] StDone    = 2'd2;
  localparam logic [1:0] StAbandon = 2'd3;

  // configuration register indexes
  localparam logic [1:0] RegLeaderOne  = 2'd0;
  localparam logic [1:0] RegLeaderTwo  = 2'd1;
  localparam logic [1:0] RegHeaderLen  = 2'd2;
  localparam logic [1:0] RegMaxFrame   = 2'd3;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // smallest frame that can carry a data byte
  localparam logic [16:0] MinFrameLen = 17'd6;

  typedef struct packed {
    logic [7:0]  leader_one;
    logic [7:0]  leader_two;
    logic [7:0]  header_length;
    logic [15:0] max_frame_length;
  } llfp_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_byte;
    logic [15:0] frame_offset;
  } llfp_result_t;

endpackage

@@ sv/llfp_cfg.sv @@
`timescale 1ns / 1ps
// configuration register bank
module llfp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [llfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [llfp_pkg::CfgDataW-1:0] cfg_wdata_i,
  output llfp_pkg::llfp_cfg_t           cfg_o
);
  import llfp_pkg::*;

  llfp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_one       <= 8'd0;
      cfg_q.leader_two       <= 8'd0;
      cfg_q.header_length    <= 8'd6;
      cfg_q.max_frame_length <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLeaderOne: cfg_q.leader_one       <= cfg_wdata_i[7:0];
        RegLeaderTwo: cfg_q.leader_two       <= cfg_wdata_i[7:0];
        RegHeaderLen: cfg_q.header_length    <= cfg_wdata_i[7:0];
        RegMaxFrame:  cfg_q.max_frame_length <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/llfp_core.sv @@
`timescale 1ns / 1ps
// parse state machine: one byte per step, result formed combinationally
module llfp_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  llfp_pkg::llfp_cfg_t    cfg_i,
  output llfp_pkg::llfp_result_t res_o
);
  import llfp_pkg::*;

  localparam logic [2:0] PhLead1 = 3'd0;
  localparam logic [2:0] PhLead2 = 3'd1;
  localparam logic [2:0] PhHlen  = 3'd2;
  localparam logic [2:0] PhExtL  = 3'd3;
  localparam logic [2:0] PhExtH  = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  hlen_q, hlen_d;
  logic [15:0] ext_q, ext_d;

  logic [15:0] ext_new;
  logic [16:0] total_new;
  logic [16:0] total_cur;
  logic [16:0] count_next;

  assign ext_new    = {byte_i, ext_q[7:0]};
  assign total_new  = {9'd0, hlen_q} + {1'b0, ext_new};
  assign total_cur  = {9'd0, hlen_q} + {1'b0, ext_q};
  assign count_next = {1'b0, count_q} + 17'd1;

  always_comb begin
    phase_d            = phase_q;
    count_d            = count_q;
    hlen_d             = hlen_q;
    ext_d              = ext_q;
    res_o.status       = StStored;
    res_o.frame_byte   = byte_i;
    res_o.frame_offset = count_q;
    unique case (phase_q)
      PhLead2: begin
        res_o.frame_offset = 16'd1;
        if (byte_i == cfg_i.leader_two) begin
          phase_d = PhHlen;
          count_d = 16'd2;
        end else begin
          // bad second leader is consumed, not retried as a first leader
          res_o.status = StAbandon;
          phase_d      = PhLead1;
          count_d      = 16'd0;
        end
      end
      PhHlen: begin
        res_o.frame_offset = 16'd2;
        hlen_d  = byte_i;
        phase_d = PhExtL;
        count_d = 16'd3;
      end
      PhExtL: begin
        res_o.frame_offset = 16'd3;
        ext_d   = {8'd0, byte_i};
        phase_d = PhExtH;
        count_d = 16'd4;
      end
      PhExtH: begin
        res_o.frame_offset = 16'd4;
        ext_d = ext_new;
        if (total_new > {1'b0, cfg_i.max_frame_length} ||
            hlen_q != cfg_i.header_length || total_new < MinFrameLen) begin
          res_o.status = StAbandon;
          phase_d      = PhLead1;
          count_d      = 16'd0;
        end else begin
          phase_d = PhData;
          count_d = 16'd5;
        end
      end
      PhData: begin
        if (count_next >= total_cur) begin
          res_o.status = StDone;
          phase_d      = PhLead1;
          count_d      = 16'd0;
        end else begin
          count_d = count_next[15:0];
        end
      end
      default: begin
        // first leader hunt, also taken by unused phase codes
        res_o.frame_offset = 16'd0;
        if (byte_i == cfg_i.leader_one) begin
          phase_d = PhLead2;
          count_d = 16'd1;
        end else begin
          res_o.status = StHunt;
          phase_d      = PhLead1;
          count_d      = 16'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead1;
      count_q <= 16'd0;
      hlen_q  <= 8'd0;
      ext_q   <= 16'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      hlen_q  <= hlen_d;
      ext_q   <= ext_d;
    end
  end

endmodule

@@ sv/leader_length_frame_parser.sv @@
`timescale 1ns / 1ps
// top level of the leader/length frame parser
//
// takes received bytes one beat at a time, hunts for the two leader bytes,
// reads the header-length byte and the little-endian 16-bit extension length,
// and then passes data bytes until header length plus extension length bytes
// have gone by. every input beat yields exactly one result beat carrying the
// byte, its offset in the frame and a status (hunting, stored, frame complete,
// frame abandoned). a frame is abandoned on a wrong second leader, a header
// length other than the configured one, or a total above max_frame_length or
// below six. throughput is one byte per clock while out_ready_i is not holding
// the result back: the byte sits in an input register, the parse step runs
// combinationally between that register and the result register, which
// drives the result beat. configuration registers are written through
// a plain write port (index 0 leader_one, 1 leader_two, 2 header_length,
// 3 max_frame_length) and should only be written while the block is idle.
module leader_length_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [llfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [llfp_pkg::CfgDataW-1:0] cfg_wdata_i,
  // received byte channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [7:0]                    frame_byte_o,
  output logic [15:0]                   frame_offset_o
);
  import llfp_pkg::*;

  llfp_cfg_t    cfg;
  llfp_result_t res;

  // input stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  // result stage
  logic         out_vld_q;
  llfp_result_t out_q;

  logic out_free;
  logic step;

  // the result slot is free when empty or being drained this cycle
  assign out_free   = !out_vld_q || out_ready_i;
  // a held byte is parsed when it can land in the result slot
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || step;

  llfp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  llfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // input byte payload, loaded on each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_q.status;
  assign frame_byte_o   = out_q.frame_byte;
  assign frame_offset_o = out_q.frame_offset;

endmodule

@@ bench/tb_leader_length_frame_parser.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the leader/length frame parser
module tb_leader_length_frame_parser;
  import llfp_pkg::*;

  // phases of the parse, mirrored in the predictor
  typedef enum logic [2:0] {
    PhLead1, PhLead2, PhHdrLen, PhExtLo, PhExtHi, PhData
  } parse_ph_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          rx_byte_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          status_o;
  logic [7:0]          frame_byte_o;
  logic [15:0]         frame_offset_o;

  leader_length_frame_parser DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .frame_byte_o   (frame_byte_o),
    .frame_offset_o (frame_offset_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: shadow of the register file and the parse state
  llfp_cfg_t    cfg_shadow = {8'h00, 8'h00, 8'd6, 16'd256};
  parse_ph_e    phase      = PhLead1;
  logic [15:0]  byte_pos   = '0;
  logic [7:0]   hdr_seen   = '0;
  logic [15:0]  ext_len    = '0;

  llfp_result_t expected_results[$];  // one per accepted byte, oldest first
  logic [7:0]   rx_stream[$];         // bytes still to be sent in this phase
  int           err_cnt    = 0;
  bit           idle_on    = 1'b1;    // cleared for stretches with no idling
  int           stall_left = 0;

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int idle_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // expected result for one received byte; advances the shadow parse state
  function automatic llfp_result_t parse_byte(logic [7:0] b);
    llfp_result_t r;
    logic [16:0]  total;
    r.status       = StStored;
    r.frame_byte   = b;
    r.frame_offset = byte_pos;
    total = {9'd0, hdr_seen} + {1'b0, ext_len};
    case (phase)
      PhLead2: begin
        r.frame_offset = 16'd1;
        if (b == cfg_shadow.leader_two) begin
          phase    = PhHdrLen;
          byte_pos = 16'd2;
        end else begin
          // wrong second leader is consumed, never retried as a first leader
          r.status = StAbandon;
          phase    = PhLead1;
          byte_pos = '0;
        end
      end
      PhHdrLen: begin
        r.frame_offset = 16'd2;
        hdr_seen = b;
        phase    = PhExtLo;
        byte_pos = 16'd3;
      end
      PhExtLo: begin
        r.frame_offset = 16'd3;
        ext_len  = {8'h00, b};
        phase    = PhExtHi;
        byte_pos = 16'd4;
      end
      PhExtHi: begin
        r.frame_offset = 16'd4;
        ext_len = {b, ext_len[7:0]};
        // 17-bit sum, so a large header plus extension never wraps
        total = {9'd0, hdr_seen} + {1'b0, ext_len};
        if (total > {1'b0, cfg_shadow.max_frame_length} ||
            hdr_seen != cfg_shadow.header_length || total < MinFrameLen) begin
          r.status = StAbandon;
          phase    = PhLead1;
          byte_pos = '0;
        end else begin
          phase    = PhData;
          byte_pos = 16'd5;
        end
      end
      PhData: begin
        if ({1'b0, byte_pos} + 17'd1 >= total) begin
          // last byte of the frame is consumed, next byte starts a new hunt
          r.status = StDone;
          phase    = PhLead1;
          byte_pos = '0;
        end else begin
          byte_pos = byte_pos + 16'd1;
        end
      end
      default: begin
        r.frame_offset = '0;
        if (b == cfg_shadow.leader_one) begin
          phase    = PhLead2;
          byte_pos = 16'd1;
        end else begin
          r.status = StHunt;
          phase    = PhLead1;
          byte_pos = '0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // result side: random back-pressure on the output channel
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left  = idle_len();
    end
  end

  // every result beat is checked against the oldest expectation
  always @(posedge clk_i) begin
    llfp_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", {14'd0, status_o}, '0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", {14'd0, status_o}, {14'd0, want.status});
        if (frame_byte_o !== want.frame_byte)
          report_mismatch("frame_byte", {8'd0, frame_byte_o}, {8'd0, want.frame_byte});
        if (frame_offset_o !== want.frame_offset)
          report_mismatch("frame_offset", frame_offset_o, want.frame_offset);
      end
    end
  end

  // send every byte queued in rx_stream, with random gaps between beats;
  // valid stays high across back-to-back beats and drops at the end
  task automatic send_bytes();
    int         gap;
    logic [7:0] b;
    while (rx_stream.size() != 0) begin
      b   = rx_stream.pop_front();
      gap = idle_len();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      rx_byte_i  <= b;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      expected_results.push_back(parse_byte(b));
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    // let the two-stage pipe settle
    repeat (4) @(posedge clk_i);
  endtask

  // write all four registers; only called with nothing in flight
  task automatic set_config(input logic [7:0] l1, input logic [7:0] l2,
                            input logic [7:0] hl, input logic [15:0] mx);
    logic [7:0] junk;
    wait_drained();
    // upper bits of the 8-bit registers carry junk that must be dropped
    junk = 8'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegLeaderOne;
    cfg_wdata_i <= {junk, l1};
    @(posedge clk_i);
    junk = 8'($urandom);
    cfg_idx_i   <= RegLeaderTwo;
    cfg_wdata_i <= {junk, l2};
    @(posedge clk_i);
    junk = 8'($urandom);
    cfg_idx_i   <= RegHeaderLen;
    cfg_wdata_i <= {junk, hl};
    @(posedge clk_i);
    cfg_idx_i   <= RegMaxFrame;
    cfg_wdata_i <= mx;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_shadow = {l1, l2, hl, mx};
  endtask

  // leaders, header length, extension length (low byte first), data bytes
  task automatic add_frame(input logic [7:0] hl, input logic [15:0] ext, input int ndata);
    rx_stream.push_back(cfg_shadow.leader_one);
    rx_stream.push_back(cfg_shadow.leader_two);
    rx_stream.push_back(hl);
    rx_stream.push_back(ext[7:0]);
    rx_stream.push_back(ext[15:8]);
    repeat (ndata) rx_stream.push_back(8'($urandom));
  endtask

  // mostly well-formed frames with random content, the rest broken or noise
  task automatic build_traffic(input int target);
    int         r, lo, cap, total, hl, over;
    logic [7:0] bad;
    logic [15:0] ext;
    hl  = cfg_shadow.header_length;
    lo  = (hl > 6) ? hl : 6;
    cap = (cfg_shadow.max_frame_length < hl + 30) ? cfg_shadow.max_frame_length : hl + 30;
    while (rx_stream.size() < target) begin
      r     = $urandom_range(99);
      total = $urandom_range(cap, lo);
      bad   = 8'($urandom_range(255, 1));
      if (r < 62) begin
        add_frame(8'(hl), 16'(total - hl), total - 5);
      end else if (r < 70) begin
        // cut short: whatever follows lands in the data phase
        add_frame(8'(hl), 16'(total - hl), $urandom_range(total - 6));
      end else if (r < 78) begin
        rx_stream.push_back(cfg_shadow.leader_one);
        rx_stream.push_back(cfg_shadow.leader_two ^ bad);
      end else if (r < 85) begin
        add_frame(8'(hl) ^ bad, 16'($urandom_range(40)), 0);
      end else if (r < 91) begin
        over = cfg_shadow.max_frame_length - hl + $urandom_range(300, 1);
        ext  = (over > 65535) ? 16'hFFFF : 16'(over);
        add_frame(8'(hl), ext, 0);
      end else begin
        repeat ($urandom_range(6, 1)) rx_stream.push_back(8'($urandom));
      end
    end
  endtask

  // register values straight out of reset: both leaders zero, length 6, max 256
  task automatic test_reset_values();
    rx_stream = {8'h5A, 8'h00, 8'h00, 8'h06, 8'h00, 8'h00, 8'hC3,
                 8'h00, 8'h00, 8'h06, 8'hFB, 8'h00};
    send_bytes();
  endtask

  // smallest frame, wrong second leader, header length and size rejections
  task automatic test_leaders_and_rejects();
    set_config(8'hFF, 8'h00, 8'd6, 16'd6);
    rx_stream = {8'hFF, 8'h00, 8'h06, 8'h00, 8'h00, 8'hA5,
                 8'hFF, 8'hFF, 8'h00,
                 8'hFF, 8'h00, 8'h07, 8'h00, 8'h00,
                 8'hFF, 8'h00, 8'h06, 8'h01, 8'h00};
    send_bytes();
    // largest header plus largest extension must not wrap past the limit
    set_config(8'h00, 8'hFF, 8'hFF, 16'hFFFF);
    rx_stream = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, 8'hFF, 8'hFE, 8'h00, 8'h00, 8'h7E};
    send_bytes();
  endtask

  // header length below six: a total under six cannot hold a data byte
  task automatic test_tiny_frame();
    set_config(8'h3C, 8'hC3, 8'd3, 16'd100);
    rx_stream = {8'h3C, 8'hC3, 8'h03, 8'h02, 8'h00,
                 8'h3C, 8'hC3, 8'h03, 8'h03, 8'h00, 8'h11};
    send_bytes();
  endtask

  // random traffic over several register settings, extremes among them
  task automatic test_random_traffic();
    logic [7:0]  l1, l2, hl;
    logic [15:0] mx;
    for (int s = 0; s < 6; s++) begin
      l1 = 8'($urandom);
      l2 = 8'($urandom);
      hl = 8'($urandom_range(12, 6));
      mx = 16'($urandom_range(60, hl + 2));
      case (s)
        2: begin
          l2 = l1;
        end
        3: begin
          hl = 8'd255;
          mx = 16'hFFFF;
        end
        4: begin
          l1 = 8'h00;
          l2 = 8'hFF;
          mx = {8'h00, hl};
        end
        5: begin
          l1 = 8'hFF;
          hl = 8'($urandom_range(40, 6));
          mx = 16'($urandom_range(90, hl));
        end
        default: ;
      endcase
      set_config(l1, l2, hl, mx);
      idle_on = (s != 1);
      build_traffic(240);
      send_bytes();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_leaders_and_rejects();
    test_tiny_frame();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
